// ===== src/crc8_framed_packet_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// CRC-8 framed packet receiver assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CRC8_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define CRC8FPR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// check on every clock edge, reset included
`define CRC8FPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define CRC8FPR_ASSERT_RST(label, prop, msg)
`define CRC8FPR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== src/crc8fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-8 framed packet receiver package
// Shared result type, result kind codes, register indexes and CRC update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc8fpr_pkg;

    // result kind codes
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    // configuration register indexes
    localparam logic CFG_IDX_START  = 1'b0;
    localparam logic CFG_IDX_SECOND = 1'b1;

    // register reset values
    localparam logic [7:0] START_MARKER_RST  = 8'hA0;
    localparam logic [7:0] SECOND_MARKER_RST = 8'h00;

    // reflected Dallas/Maxim polynomial
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] source_address;
        logic [7:0] payload_length;
        logic       last_of_packet;
    } t_result;

    // one byte of the reflected CRC-8, bit at a time
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY_REFL;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

// ===== src/crc8fpr_parser.sv =====
// ----------------------------------------------------------------------------
// CRC-8 framed packet receiver frame parser
// Phase sequencer and running check; forms one result per payload/check byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "crc8_framed_packet_receiver_assert.svh"

module crc8fpr_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_rx_byte,
    input  logic [7:0]           i_start_marker,
    input  logic [7:0]           i_second_marker,
    output logic                 o_res_valid,
    output crc8fpr_pkg::t_result o_res
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_ADDR    = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_len, n_len;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_check, n_check;
    logic [7:0] w_crc_in;
    logic [7:0] w_crc_out;

    // start a fresh check at the second marker, otherwise continue
    assign w_crc_in  = (r_phase == PH_SECOND) ? 8'h00 : r_check;
    assign w_crc_out = crc8fpr_pkg::crc8_update(w_crc_in, i_rx_byte);

    // step the frame phase for the byte in hand
    always_comb begin
        n_phase     = r_phase;
        n_addr      = r_addr;
        n_len       = r_len;
        n_rem       = r_rem;
        n_check     = r_check;
        o_res_valid = 1'b0;
        o_res.kind           = crc8fpr_pkg::KIND_PAYLOAD;
        o_res.data_byte      = i_rx_byte;
        o_res.source_address = r_addr;
        o_res.payload_length = r_len;
        o_res.last_of_packet = 1'b0;
        case (r_phase)
            PH_SECOND: begin
                if (i_rx_byte == i_second_marker) begin
                    n_check = w_crc_out;
                    n_phase = PH_ADDR;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_ADDR: begin
                n_addr  = i_rx_byte;
                n_check = w_crc_out;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_rx_byte;
                n_rem   = i_rx_byte;
                n_phase = (i_rx_byte == 8'h00) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_check     = w_crc_out;
                n_rem       = r_rem - 8'd1;
                n_phase     = (r_rem == 8'd1) ? PH_CHECK : PH_PAYLOAD;
                o_res_valid = 1'b1;
            end
            PH_CHECK: begin
                n_phase     = PH_HUNT;
                o_res_valid = 1'b1;
                o_res.kind  = (i_rx_byte == r_check) ? crc8fpr_pkg::KIND_GOOD
                                                     : crc8fpr_pkg::KIND_BAD;
                o_res.last_of_packet = 1'b1;
            end
            default: begin
                n_phase = (i_rx_byte == i_start_marker) ? PH_SECOND : PH_HUNT;
            end
        endcase
    end

    // hold state unless a byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_addr  <= 8'h00;
            r_len   <= 8'h00;
            r_rem   <= 8'h00;
            r_check <= 8'h00;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_check <= n_check;
        end
    end

    `CRC8FPR_ASSERT_RST(a_payload_count_nonzero,
        (r_phase == PH_PAYLOAD) |-> (r_rem != 8'h00),
        "payload phase entered with no bytes remaining")
    `CRC8FPR_ASSERT_RST(a_check_ends_packet,
        (i_advance && r_phase == PH_CHECK) |=> (r_phase == PH_HUNT),
        "check byte did not return parser to hunting")

endmodule

// ===== src/crc8fpr_out_fifo.sv =====
// ----------------------------------------------------------------------------
// CRC-8 framed packet receiver output buffer
// Two-entry result queue that parts the parser from the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "crc8_framed_packet_receiver_assert.svh"

module crc8fpr_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  crc8fpr_pkg::t_result i_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output crc8fpr_pkg::t_result o_data,
    output logic                 o_full
);

    crc8fpr_pkg::t_result r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && !i_stall;

    // store a request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CRC8FPR_ASSERT_RST(a_no_push_when_full,
        !(i_push && o_full),
        "request pushed into full output buffer")
    `CRC8FPR_ASSERT_RST(a_count_matches_ptrs,
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr),
        "output buffer count disagrees with pointers")

endmodule

// ===== src/crc8_framed_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// CRC-8 framed packet receiver
// Parses start/second marker framed packets and checks a Maxim CRC-8.
// ----------------------------------------------------------------------------
// Input channel: one received byte per request on i_rx_byte, taken when
//   i_in_valid is high and o_in_stall is low.
// Result channel: o_kind, o_data_byte, o_source_address, o_payload_length
//   and o_last_of_packet, taken when o_out_valid is high and i_out_stall low.
//   Payload bytes give one result each; the check byte gives one status
//   result with o_last_of_packet set. Header bytes give no result.
// Configuration: i_cfg_index 0 writes the start marker, 1 the second marker;
//   o_cfg_ready is always high, so a write lands on any valid cycle.
// Path: a byte is held in the input register; parser logic then writes its
//   result into a two-entry output buffer, which drives the outputs.
// Throughput: one byte per cycle unless the output buffer is full; the CRC
//   update and phase step are combinational logic after the input register.
// Stall: when the result channel stalls, the output buffer fills and then
//   o_in_stall rises; o_in_stall comes from registers only.
// Reset: synchronous active low; the parser returns to hunting, the markers
//   return to 0xA0 and 0x00 and all buffered requests are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc8_framed_packet_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_source_address,
    output logic [7:0] o_payload_length,
    output logic       o_last_of_packet,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [7:0] r_start_marker;
    logic [7:0] r_second_marker;
    logic       w_accept;
    logic       w_advance;
    logic       w_fifo_full;
    logic       w_res_valid;
    crc8fpr_pkg::t_result w_res;
    crc8fpr_pkg::t_result w_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_valid && w_fifo_full;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_advance   = r_in_valid && !w_fifo_full;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker  <= crc8fpr_pkg::START_MARKER_RST;
            r_second_marker <= crc8fpr_pkg::SECOND_MARKER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                crc8fpr_pkg::CFG_IDX_START:  r_start_marker  <= i_cfg_data;
                crc8fpr_pkg::CFG_IDX_SECOND: r_second_marker <= i_cfg_data;
                default:                     r_start_marker  <= r_start_marker;
            endcase
        end
    end

    // hold the accepted byte until the parser consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    crc8fpr_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_advance),
        .i_rx_byte       (r_in_byte),
        .i_start_marker  (r_start_marker),
        .i_second_marker (r_second_marker),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    crc8fpr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_advance && w_res_valid),
        .i_data  (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .o_full  (w_fifo_full)
    );

    assign o_kind           = w_out.kind;
    assign o_data_byte      = w_out.data_byte;
    assign o_source_address = w_out.source_address;
    assign o_payload_length = w_out.payload_length;
    assign o_last_of_packet = w_out.last_of_packet;

endmodule

// ===== tb/sv/tb_crc8_framed_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// CRC-8 framed packet receiver testbench
// Drives framed packets, broken headers and line noise into the receiver with
// random gaps and output back-pressure. A scoreboard class runs its own copy
// of the packet parser and the Maxim CRC-8, and compares every result
// request field by field. The test walks through several marker settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_crc8_framed_packet_receiver;

    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int BYTES_PER_SET = 250;

    // parser phases as the scoreboard tracks them
    typedef enum logic [2:0] {
        P_HUNT, P_SECOND, P_ADDR, P_LEN, P_PAYLOAD, P_CHECK
    } t_phase;

    // ------------------------------------------------------------------------
    // Scoreboard: parses accepted bytes and holds the results they imply
    // ------------------------------------------------------------------------
    class frame_tracker;
        crc8fpr_pkg::t_result pending_out[$];
        int         errors;
        t_phase     phase;
        logic [7:0] start_mk;
        logic [7:0] second_mk;
        logic [7:0] addr;
        logic [7:0] len;
        logic [7:0] remaining;
        logic [7:0] crc;

        function new();
            errors    = 0;
            phase     = P_HUNT;
            start_mk  = crc8fpr_pkg::START_MARKER_RST;
            second_mk = crc8fpr_pkg::SECOND_MARKER_RST;
            addr      = 8'h00;
            len       = 8'h00;
            remaining = 8'h00;
            crc       = 8'h00;
        endfunction

        // one byte of the reflected Maxim CRC-8, shifting data bits in serially
        static function logic [7:0] crc_step(logic [7:0] c_in, logic [7:0] b);
            logic [7:0] c;
            logic       fb;
            c = c_in;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ crc8fpr_pkg::CRC_POLY_REFL;
                end
            end
            return c;
        endfunction

        function void report(string msg);
            if (errors < 100) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
            errors++;
        endfunction

        function void note_config(logic idx, logic [7:0] val);
            if (idx == crc8fpr_pkg::CFG_IDX_START) begin
                start_mk = val;
            end else begin
                second_mk = val;
            end
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] data, logic last);
            crc8fpr_pkg::t_result r;
            r.kind           = kind;
            r.data_byte      = data;
            r.source_address = addr;
            r.payload_length = len;
            r.last_of_packet = last;
            pending_out.push_back(r);
        endfunction

        // advance the parser by one accepted byte
        function void take_byte(logic [7:0] b);
            case (phase)
                P_SECOND: begin
                    if (b == second_mk) begin
                        crc   = crc_step(8'h00, b);
                        phase = P_ADDR;
                    end else begin
                        phase = P_HUNT;
                    end
                end
                P_ADDR: begin
                    addr  = b;
                    crc   = crc_step(crc, b);
                    phase = P_LEN;
                end
                P_LEN: begin
                    len       = b;
                    remaining = b;
                    phase     = (b == 8'h00) ? P_CHECK : P_PAYLOAD;
                end
                P_PAYLOAD: begin
                    crc       = crc_step(crc, b);
                    remaining = remaining - 8'd1;
                    if (remaining == 8'h00) begin
                        phase = P_CHECK;
                    end
                    push_result(crc8fpr_pkg::KIND_PAYLOAD, b, 1'b0);
                end
                P_CHECK: begin
                    phase = P_HUNT;
                    push_result((b == crc) ? crc8fpr_pkg::KIND_GOOD
                                           : crc8fpr_pkg::KIND_BAD, b, 1'b1);
                end
                default: begin
                    phase = (b == start_mk) ? P_SECOND : P_HUNT;
                end
            endcase
        endfunction

        // compare one result request with the oldest expected one
        function void check_output(logic [1:0] kind, logic [7:0] data, logic [7:0] src,
                                   logic [7:0] plen, logic last);
            crc8fpr_pkg::t_result want;
            if (pending_out.size() == 0) begin
                report($sformatf("unexpected result kind %0d data %02h", kind, data));
                return;
            end
            want = pending_out.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", kind, want.kind));
            if (data !== want.data_byte)
                report($sformatf("data_byte %02h, expected %02h", data, want.data_byte));
            if (src !== want.source_address)
                report($sformatf("source_address %02h, expected %02h",
                                 src, want.source_address));
            if (plen !== want.payload_length)
                report($sformatf("payload_length %02h, expected %02h",
                                 plen, want.payload_length));
            if (last !== want.last_of_packet)
                report($sformatf("last_of_packet %0b, expected %0b",
                                 last, want.last_of_packet));
        endfunction

        function void flag_leftovers();
            if (pending_out.size() != 0) begin
                report($sformatf("%0d expected results never arrived", pending_out.size()));
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_kind;
    logic [7:0] o_data_byte;
    logic [7:0] o_source_address;
    logic [7:0] o_payload_length;
    logic       o_last_of_packet;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    frame_tracker sb;
    logic [7:0]   cur_start;
    logic [7:0]   cur_second;
    int           framed_bytes;
    bit           calm;
    bit           long_hold_req;
    int           stall_left;

    crc8_framed_packet_receiver u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_source_address (o_source_address),
        .o_payload_length (o_payload_length),
        .o_last_of_packet (o_last_of_packet),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // end the run if it hangs
    initial begin
        #8000000;
        $display("crc8_framed_packet_receiver: mismatch");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int short_or_long_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // output back-pressure: random bursts, plus one long hold on request
    initial begin
        i_out_stall = 1'b0;
        stall_left  = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
                i_out_stall   = 1'b0;
            end else if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
                if (!calm && $urandom_range(0, 99) < 20) begin
                    stall_left = short_or_long_gap();
                end
            end
        end
    end

    // check every result request taken at a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_output(o_kind, o_data_byte, o_source_address,
                            o_payload_length, o_last_of_packet);
        end
    end

    // offer one byte and hold it until the receiver takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 55) ? 0 : short_or_long_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte  = b;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_byte(b);
    endtask

    // send start, second marker, address, length, payload and check byte
    task automatic send_packet(input logic [7:0] addr, input logic [7:0] body[$],
                               input bit bad_check, input bit bad_second);
        logic [7:0] chk;
        logic [7:0] second;
        second = bad_second ? (cur_second ^ 8'($urandom_range(1, 255))) : cur_second;
        chk    = frame_tracker::crc_step(8'h00, second);
        chk    = frame_tracker::crc_step(chk, addr);
        foreach (body[i]) begin
            chk = frame_tracker::crc_step(chk, body[i]);
        end
        if (bad_check) begin
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        send_byte(cur_start);
        send_byte(second);
        send_byte(addr);
        send_byte(8'(body.size()));
        foreach (body[i]) begin
            send_byte(body[i]);
        end
        send_byte(chk);
        framed_bytes += body.size() + 5;
    endtask

    // drop valid and wait until every expected result has come out
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, val);
        if (idx == crc8fpr_pkg::CFG_IDX_START) begin
            cur_start = val;
        end else begin
            cur_second = val;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one random unit: a packet (sometimes broken) or a burst of line noise
    task automatic random_unit();
        logic [7:0] body[$];
        int         pick;
        int         n;
        pick = $urandom_range(0, 99);
        calm = ($urandom_range(0, 7) == 0);
        if (pick < 15) begin
            repeat ($urandom_range(1, 6)) begin
                send_byte(($urandom_range(0, 4) == 0) ? cur_start : 8'($urandom));
            end
        end else begin
            n = $urandom_range(0, 99);
            if (n < 2) begin
                n = 255;
            end else if (n < 90) begin
                n = $urandom_range(0, 12);
            end else begin
                n = $urandom_range(13, 64);
            end
            repeat (n) body.push_back(8'($urandom));
            send_packet(8'($urandom), body, $urandom_range(0, 3) == 0, pick < 25);
        end
        calm = 1'b0;
    endtask

    initial begin
        logic [7:0] body[$];
        logic [7:0] shared;
        int         target;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_rx_byte     = 8'h00;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = crc8fpr_pkg::CFG_IDX_START;
        i_cfg_data    = 8'h00;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        framed_bytes  = 0;
        cur_start     = crc8fpr_pkg::START_MARKER_RST;
        cur_second    = crc8fpr_pkg::SECOND_MARKER_RST;
        sb            = new();

        // hold reset, then release it on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero-length packet with the highest address
        body = {};
        send_packet(8'hFF, body, 1'b0, 1'b0);
        // second marker mismatch: the repeated start byte must not reopen a packet
        send_byte(crc8fpr_pkg::START_MARKER_RST);
        send_byte(crc8fpr_pkg::START_MARKER_RST);
        repeat (4) send_byte(8'h00);
        // extreme payload bytes with a bad check, then a good one-byte packet
        body = {8'h00, 8'hFF};
        send_packet(8'h00, body, 1'b1, 1'b0);
        body = {8'h80};
        send_packet(8'h5A, body, 1'b0, 1'b0);

        for (int ph = 0; ph < 5; ph++) begin
            // change markers only while the block is idle
            if (ph > 0) begin
                wait_for_results();
            end
            case (ph)
                1: begin
                    write_reg(crc8fpr_pkg::CFG_IDX_START, 8'h00);
                    write_reg(crc8fpr_pkg::CFG_IDX_SECOND, 8'hFF);
                end
                2: begin
                    write_reg(crc8fpr_pkg::CFG_IDX_START, 8'hFF);
                    write_reg(crc8fpr_pkg::CFG_IDX_SECOND, 8'h00);
                end
                3: begin
                    write_reg(crc8fpr_pkg::CFG_IDX_START, 8'($urandom));
                    write_reg(crc8fpr_pkg::CFG_IDX_SECOND, 8'($urandom));
                end
                4: begin
                    shared = 8'($urandom);
                    write_reg(crc8fpr_pkg::CFG_IDX_START, shared);
                    write_reg(crc8fpr_pkg::CFG_IDX_SECOND, shared);
                end
                default: ;
            endcase
            // hold the output off while a long packet keeps coming
            if (ph == 1) begin
                body = {};
                repeat (40) body.push_back(8'($urandom));
                calm          = 1'b1;
                long_hold_req = 1'b1;
                send_packet(8'($urandom), body, 1'b0, 1'b0);
                calm          = 1'b0;
            end
            target = framed_bytes + BYTES_PER_SET;
            while (framed_bytes < target) random_unit();
        end

        wait_for_results();
        sb.flag_leftovers();
        if (sb.errors == 0) begin
            $display("crc8_framed_packet_receiver: match");
        end else begin
            $display("crc8_framed_packet_receiver: mismatch");
        end
        $finish;
    end

endmodule
